// ===== rtl/c8ic_pkg.sv =====
// shared types, constants and command codes for the chip8 instruction core
// no dependencies
package c8ic_pkg;

  localparam int MEM_BYTES     = 4096;
  localparam int STACK_DEPTH   = 16;
  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_HEIGHT = 32;

  localparam int MEM_AW   = $clog2(MEM_BYTES);
  localparam int STACK_AW = $clog2(STACK_DEPTH);
  localparam int SP_W     = $clog2(STACK_DEPTH + 1);
  localparam int ROW_AW   = $clog2(SCREEN_HEIGHT);
  localparam int COL_AW   = $clog2(SCREEN_WIDTH);

  localparam logic [11:0] PC_START = 12'h200;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_EXEC  = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNKNOWN   = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_UNDERFLOW = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLEAR,
    OP_CAPTURE,
    OP_MEM_WR,
    OP_ROW_RD,
    OP_ROW_LAT,
    OP_FETCH_HI,
    OP_FETCH_LO,
    OP_READ_X,
    OP_READ_Y,
    OP_EXEC,
    OP_DRAW_RD,
    OP_DRAW_WR,
    OP_DRAW_END,
    OP_FLAG,
    OP_LOAD_OUT
  } dp_op_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [11:0] address;
    logic [7:0]  data_byte;
    logic [7:0]  random_byte;
    logic [4:0]  row_select;
  } in_t;

  typedef struct packed {
    logic [11:0] pc_after;
    logic [15:0] opcode_done;
    logic [1:0]  status;
    logic        collision;
    logic        draw_done;
    logic [63:0] display_row;
  } out_t;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic is_draw;
    logic draw_more;
  } dp_status_t;

endpackage

// ===== rtl/chip8_instruction_core.sv =====
// chip8 instruction core: after reset the 4096-byte program memory is cleared
// one byte per cycle, so no transaction is taken until that sweep has ended;
// a sprite draw handles each sprite row by reading program memory and the
// display row together, then writing the xor back to the display row
// one item at a time; a finished result waits in the output register while
// the next transaction is taken. reset is asynchronous, active low
module chip8_instruction_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  c8ic_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output c8ic_pkg::out_t out_data_o
);

  // command from the sequencer, status back from the datapath
  c8ic_pkg::dp_cmd_t    cmd;
  c8ic_pkg::dp_status_t st;

  // sequencer: clear sweep, byte write, row read, fetch, register reads, execute, draw loop, flag write, output
  c8ic_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_mode_i   (in_data_i.mode),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  // datapath: memories, register file, return stack, alu and sprite xor
  c8ic_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .st_o       (st),
    .out_data_o (out_data_o)
  );

endmodule

// ===== rtl/c8ic_ctrl.sv =====
// controller state machine of the chip8 instruction core
// depends on c8ic_pkg
module c8ic_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           in_mode_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  c8ic_pkg::dp_status_t st_i,
  output c8ic_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_WRITE, S_ROWRD, S_ROWLAT, S_FHI, S_FLO,
    S_RVX, S_RVY, S_EXEC, S_DRD, S_DWR, S_FLAG, S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o.op    = c8ic_pkg::OP_NOP;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.op = c8ic_pkg::OP_CLEAR;
        if (st_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = c8ic_pkg::OP_CAPTURE;
          unique case (c8ic_pkg::mode_e'(in_mode_i))
            c8ic_pkg::MODE_WRITE: state_d = S_WRITE;
            c8ic_pkg::MODE_EXEC:  state_d = S_FHI;
            c8ic_pkg::MODE_READ:  state_d = S_ROWRD;
            c8ic_pkg::MODE_NONE:  state_d = S_DONE;
            default:              state_d = S_DONE;
          endcase
        end
      end
      S_WRITE: begin
        cmd_o.op = c8ic_pkg::OP_MEM_WR;
        state_d  = S_DONE;
      end
      S_ROWRD: begin
        cmd_o.op = c8ic_pkg::OP_ROW_RD;
        state_d  = S_ROWLAT;
      end
      S_ROWLAT: begin
        cmd_o.op = c8ic_pkg::OP_ROW_LAT;
        state_d  = S_DONE;
      end
      S_FHI: begin
        cmd_o.op = c8ic_pkg::OP_FETCH_HI;
        state_d  = S_FLO;
      end
      S_FLO: begin
        cmd_o.op = c8ic_pkg::OP_FETCH_LO;
        state_d  = S_RVX;
      end
      S_RVX: begin
        cmd_o.op = c8ic_pkg::OP_READ_X;
        state_d  = S_RVY;
      end
      S_RVY: begin
        cmd_o.op = c8ic_pkg::OP_READ_Y;
        state_d  = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.op = c8ic_pkg::OP_EXEC;
        state_d  = st_i.is_draw ? S_DRD : S_FLAG;
      end
      S_DRD: begin
        if (st_i.draw_more) begin
          cmd_o.op = c8ic_pkg::OP_DRAW_RD;
          state_d  = S_DWR;
        end else begin
          cmd_o.op = c8ic_pkg::OP_DRAW_END;
          state_d  = S_FLAG;
        end
      end
      S_DWR: begin
        cmd_o.op = c8ic_pkg::OP_DRAW_WR;
        state_d  = S_DRD;
      end
      S_FLAG: begin
        cmd_o.op = c8ic_pkg::OP_FLAG;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.op    = c8ic_pkg::OP_LOAD_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/c8ic_dp.sv =====
// datapath of the chip8 instruction core: memories, registers, alu, draw unit
// depends on c8ic_pkg
module c8ic_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  c8ic_pkg::in_t        in_data_i,
  input  c8ic_pkg::dp_cmd_t    cmd_i,
  output c8ic_pkg::dp_status_t st_o,
  output c8ic_pkg::out_t       out_data_o
);

  localparam int SA = c8ic_pkg::STACK_AW;
  localparam int SW = c8ic_pkg::SP_W;
  localparam int RA = c8ic_pkg::ROW_AW;
  localparam int CA = c8ic_pkg::COL_AW;

  // storage
  logic [7:0]  mem_q [c8ic_pkg::MEM_BYTES];
  logic [63:0] disp_q [c8ic_pkg::SCREEN_HEIGHT];
  logic [c8ic_pkg::SCREEN_HEIGHT-1:0] disp_vld_q;
  logic [7:0]  v_q [16];
  logic [11:0] stack_q [c8ic_pkg::STACK_DEPTH];

  c8ic_pkg::in_t  item_q;
  c8ic_pkg::out_t out_q;
  logic [11:0] clr_q;
  logic [11:0] pc_q, i_q;
  logic [11:0] pc_d;
  logic [SW-1:0] sp_q;
  logic [7:0]  mem_rd_q, hi_q, v_rd_q, vx_q;
  logic [63:0] disp_rd_q;
  logic [15:0] opcode_q;
  logic [3:0]  r_q;
  logic [CA-1:0] px_q;
  logic [RA-1:0] py_q;
  logic        coll_q, flag_q, flag_we_q;
  logic [1:0]  res_status_q;
  logic        res_coll_q, res_drawn_q;
  logic [63:0] res_row_q;

  logic [11:0]   mem_raddr;
  logic [RA-1:0] disp_addr;
  logic [63:0]   mask;
  logic [127:0]  mask_wide;
  logic [SW-1:0] sp_m1;

  logic [3:0]  x, y, n;
  logic [7:0]  nn, vx, vy;
  logic [11:0] nnn;
  logic [8:0]  sum9;

  assign x    = opcode_q[11:8];
  assign y    = opcode_q[7:4];
  assign n    = opcode_q[3:0];
  assign nn   = opcode_q[7:0];
  assign nnn  = opcode_q[11:0];
  assign vx   = vx_q;
  assign vy   = v_rd_q;
  assign sum9 = {1'b0, vx} + {1'b0, vy};
  assign sp_m1 = sp_q - SW'(1);

  assign st_o.clear_last = (clr_q == 12'hFFF);
  assign st_o.is_draw    = (opcode_q[15:12] == 4'hD);
  assign st_o.draw_more  = (r_q != n);

  assign disp_addr = (cmd_i.op == c8ic_pkg::OP_ROW_RD) ? item_q.row_select
                                                        : py_q + RA'(r_q);
  assign mask_wide = {mem_rd_q, 56'd0, mem_rd_q, 56'd0} >> px_q;
  assign mask      = mask_wide[63:0];

  always_comb begin
    unique case (cmd_i.op)
      c8ic_pkg::OP_FETCH_LO: mem_raddr = pc_q + 12'd1;
      c8ic_pkg::OP_DRAW_RD:  mem_raddr = i_q + {8'd0, r_q};
      default:               mem_raddr = pc_q;
    endcase
  end

  // next program counter of the instruction in opcode_q
  always_comb begin
    pc_d = pc_q + 12'd2;
    unique case (opcode_q[15:12])
      4'h0: if (nn == 8'hEE && sp_q != '0) pc_d = stack_q[sp_m1[SA-1:0]] + 12'd2;
      4'h1: pc_d = nnn;
      4'h2: if (sp_q != SW'(c8ic_pkg::STACK_DEPTH)) pc_d = nnn;
      4'h3: if (vx == nn) pc_d = pc_q + 12'd4;
      4'h4: if (vx != nn) pc_d = pc_q + 12'd4;
      4'h5: if (vx == vy) pc_d = pc_q + 12'd4;
      // undefined alu selectors hold the pc
      4'h8: if (n[3] && n != 4'hE) pc_d = pc_q;
      4'h9: if (vx != vy) pc_d = pc_q + 12'd4;
      4'hB: pc_d = nnn + {4'd0, vx};
      4'hE, 4'hF: pc_d = pc_q;
      default: ;
    endcase
  end

  // program memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == c8ic_pkg::OP_CLEAR) begin
      mem_q[clr_q] <= 8'd0;
    end else if (cmd_i.op == c8ic_pkg::OP_MEM_WR) begin
      mem_q[item_q.address] <= item_q.data_byte;
    end
    mem_rd_q <= mem_q[mem_raddr];
  end

  // display rows, unwritten rows read as zero
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == c8ic_pkg::OP_DRAW_WR) begin
      disp_q[disp_addr] <= disp_rd_q ^ mask;
    end
    disp_rd_q <= disp_vld_q[disp_addr] ? disp_q[disp_addr] : 64'd0;
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == c8ic_pkg::OP_CAPTURE) item_q <= in_data_i;
    if (cmd_i.op == c8ic_pkg::OP_FETCH_LO) hi_q <= mem_rd_q;
    if (cmd_i.op == c8ic_pkg::OP_READ_X) begin
      v_rd_q <= v_q[(hi_q[7:4] == 4'hB) ? 4'd0 : hi_q[3:0]];
    end else if (cmd_i.op == c8ic_pkg::OP_READ_Y) begin
      vx_q   <= v_rd_q;
      v_rd_q <= v_q[y];
    end
    if (cmd_i.op == c8ic_pkg::OP_LOAD_OUT) begin
      out_q.pc_after    <= pc_q;
      out_q.opcode_done <= opcode_q;
      out_q.status      <= res_status_q;
      out_q.collision   <= res_coll_q;
      out_q.draw_done   <= res_drawn_q;
      out_q.display_row <= res_row_q;
    end
  end

  assign out_data_o = out_q;

  // architectural state and instruction execution
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q        <= 12'd0;
      pc_q         <= c8ic_pkg::PC_START;
      i_q          <= 12'd0;
      sp_q         <= '0;
      disp_vld_q   <= '0;
      opcode_q     <= 16'd0;
      r_q          <= 4'd0;
      px_q         <= '0;
      py_q         <= '0;
      coll_q       <= 1'b0;
      flag_q       <= 1'b0;
      flag_we_q    <= 1'b0;
      res_status_q <= c8ic_pkg::ST_OK;
      res_coll_q   <= 1'b0;
      res_drawn_q  <= 1'b0;
      res_row_q    <= 64'd0;
      for (int k = 0; k < 16; k++) v_q[k] <= 8'd0;
      for (int k = 0; k < c8ic_pkg::STACK_DEPTH; k++) stack_q[k] <= 12'd0;
    end else begin
      unique case (cmd_i.op)
        c8ic_pkg::OP_CLEAR: clr_q <= clr_q + 12'd1;
        c8ic_pkg::OP_CAPTURE: begin
          opcode_q     <= 16'd0;
          res_status_q <= c8ic_pkg::ST_OK;
          res_coll_q   <= 1'b0;
          res_drawn_q  <= 1'b0;
          res_row_q    <= 64'd0;
          flag_we_q    <= 1'b0;
        end
        c8ic_pkg::OP_ROW_LAT: res_row_q <= disp_rd_q;
        c8ic_pkg::OP_READ_X:  opcode_q  <= {hi_q, mem_rd_q};
        c8ic_pkg::OP_EXEC: begin
          pc_q <= pc_d;
          unique case (opcode_q[15:12])
            4'h0: begin
              if (nn == 8'hE0) begin
                disp_vld_q  <= '0;
                res_drawn_q <= 1'b1;
              end else if (nn == 8'hEE) begin
                if (sp_q == '0) begin
                  res_status_q <= c8ic_pkg::ST_UNDERFLOW;
                end else begin
                  sp_q <= sp_m1;
                end
              end
            end
            4'h2: begin
              if (sp_q == SW'(c8ic_pkg::STACK_DEPTH)) begin
                res_status_q <= c8ic_pkg::ST_OVERFLOW;
              end else begin
                stack_q[sp_q[SA-1:0]] <= pc_q;
                sp_q <= sp_q + SW'(1);
              end
            end
            4'h6: v_q[x] <= nn;
            4'h7: v_q[x] <= vx + nn;
            4'h8: begin
              unique case (n)
                4'h0: v_q[x] <= vy;
                4'h1: v_q[x] <= vx | vy;
                4'h2: v_q[x] <= vx & vy;
                4'h3: v_q[x] <= vx ^ vy;
                4'h4: begin
                  v_q[x] <= sum9[7:0]; flag_q <= sum9[8]; flag_we_q <= 1'b1;
                end
                4'h5: begin
                  v_q[x] <= vx - vy; flag_q <= (vx >= vy); flag_we_q <= 1'b1;
                end
                4'h6: begin
                  v_q[x] <= {1'b0, vx[7:1]}; flag_q <= vx[0]; flag_we_q <= 1'b1;
                end
                4'h7: begin
                  v_q[x] <= vy - vx; flag_q <= (vy >= vx); flag_we_q <= 1'b1;
                end
                4'hE: begin
                  v_q[x] <= {vx[6:0], 1'b0}; flag_q <= vx[7]; flag_we_q <= 1'b1;
                end
                default: res_status_q <= c8ic_pkg::ST_UNKNOWN;
              endcase
            end
            4'hA: i_q  <= nnn;
            4'hC: v_q[x] <= item_q.random_byte & nn;
            4'hD: begin
              r_q    <= 4'd0;
              px_q   <= vx[CA-1:0];
              py_q   <= vy[RA-1:0];
              coll_q <= 1'b0;
            end
            4'hE, 4'hF: res_status_q <= c8ic_pkg::ST_UNKNOWN;
            default: ;
          endcase
        end
        c8ic_pkg::OP_DRAW_WR: begin
          disp_vld_q[disp_addr] <= 1'b1;
          if ((disp_rd_q & mask) != 64'd0) coll_q <= 1'b1;
          r_q <= r_q + 4'd1;
        end
        c8ic_pkg::OP_DRAW_END: begin
          flag_q      <= coll_q;
          flag_we_q   <= 1'b1;
          res_coll_q  <= coll_q;
          res_drawn_q <= 1'b1;
        end
        c8ic_pkg::OP_FLAG: if (flag_we_q) v_q[15] <= {7'd0, flag_q};
        default: ;
      endcase
    end
  end

endmodule

// ===== tb/sv/c8ic_checker.sv =====
// checker for the chip8 instruction core: watches both channels, predicts
// each result from its own copy of the core state and compares field by field
// depends on c8ic_pkg
`timescale 1ns / 1ps

module c8ic_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  c8ic_pkg::in_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  input  c8ic_pkg::out_t out_data_i,
  output int             fail_count_o,
  output int             pending_o,
  output logic [11:0]    pc_o
);

  logic [7:0]  mem_q [c8ic_pkg::MEM_BYTES];
  logic [7:0]  vreg_q [16];
  logic [11:0] stack_q [c8ic_pkg::STACK_DEPTH];
  int          depth_q;
  logic [11:0] pc_q;
  logic [11:0] index_q;
  logic [63:0] screen_q [c8ic_pkg::SCREEN_HEIGHT];
  c8ic_pkg::out_t results_q [$];

  assign pending_o = results_q.size();
  assign pc_o      = pc_q;

  function automatic c8ic_pkg::out_t step_core(c8ic_pkg::in_t t);
    c8ic_pkg::out_t r;
    logic [11:0] pc, nxt, nnn;
    logic [15:0] op;
    logic [7:0]  a, b, nn, sb;
    logic [3:0]  x, y;
    logic [8:0]  sum;
    logic [63:0] mask;
    int          px, py;
    r = '0;
    case (c8ic_pkg::mode_e'(t.mode))
      c8ic_pkg::MODE_WRITE: mem_q[t.address] = t.data_byte;
      c8ic_pkg::MODE_READ:  r.display_row = screen_q[t.row_select];
      c8ic_pkg::MODE_EXEC: begin
        pc  = pc_q;
        nxt = pc + 12'd2;
        op  = {mem_q[pc], mem_q[pc + 12'd1]};
        x = op[11:8];
        y = op[7:4];
        nn = op[7:0];
        nnn = op[11:0];
        a = vreg_q[x];
        b = vreg_q[y];
        r.opcode_done = op;
        r.status = c8ic_pkg::ST_OK;
        case (op[15:12])
          4'h0: begin
            if (nn == 8'hE0) begin
              foreach (screen_q[i]) screen_q[i] = '0;
              r.draw_done = 1'b1;
            end else if (nn == 8'hEE) begin
              if (depth_q == 0) r.status = c8ic_pkg::ST_UNDERFLOW;
              else begin
                depth_q--;
                nxt = stack_q[depth_q] + 12'd2;
              end
            end
          end
          4'h1: nxt = nnn;
          4'h2: begin
            if (depth_q >= c8ic_pkg::STACK_DEPTH) r.status = c8ic_pkg::ST_OVERFLOW;
            else begin
              stack_q[depth_q] = pc;
              depth_q++;
              nxt = nnn;
            end
          end
          4'h3: if (a == nn) nxt = pc + 12'd4;
          4'h4: if (a != nn) nxt = pc + 12'd4;
          4'h5: if (a == b) nxt = pc + 12'd4;
          4'h6: vreg_q[x] = nn;
          4'h7: vreg_q[x] = a + nn;
          4'h8: begin
            case (op[3:0])
              4'h0: vreg_q[x] = b;
              4'h1: vreg_q[x] = a | b;
              4'h2: vreg_q[x] = a & b;
              4'h3: vreg_q[x] = a ^ b;
              4'h4: begin
                sum = a + b;
                vreg_q[x] = sum[7:0];
                vreg_q[15] = {7'd0, sum[8]};
              end
              4'h5: begin vreg_q[x] = a - b; vreg_q[15] = {7'd0, a >= b}; end
              4'h6: begin vreg_q[x] = a >> 1; vreg_q[15] = {7'd0, a[0]}; end
              4'h7: begin vreg_q[x] = b - a; vreg_q[15] = {7'd0, b >= a}; end
              4'hE: begin vreg_q[x] = a << 1; vreg_q[15] = {7'd0, a[7]}; end
              default: begin r.status = c8ic_pkg::ST_UNKNOWN; nxt = pc; end
            endcase
          end
          4'h9: if (a != b) nxt = pc + 12'd4;
          4'hA: index_q = nnn;
          4'hB: nxt = {4'd0, vreg_q[0]} + nnn;
          4'hC: vreg_q[x] = t.random_byte & nn;
          4'hD: begin
            px = a % c8ic_pkg::SCREEN_WIDTH;
            py = b % c8ic_pkg::SCREEN_HEIGHT;
            for (int k = 0; k < op[3:0]; k++) begin
              sb = mem_q[index_q + 12'(k)];
              mask = {sb, 56'd0} >> px;
              if (px != 0) mask |= {sb, 56'd0} << (64 - px);
              if ((screen_q[(py + k) % c8ic_pkg::SCREEN_HEIGHT] & mask) != 0)
                r.collision = 1'b1;
              screen_q[(py + k) % c8ic_pkg::SCREEN_HEIGHT] ^= mask;
            end
            vreg_q[15] = {7'd0, r.collision};
            r.draw_done = 1'b1;
          end
          default: begin r.status = c8ic_pkg::ST_UNKNOWN; nxt = pc; end
        endcase
        pc_q = nxt;
      end
      default: ;
    endcase
    r.pc_after = pc_q;
    return r;
  endfunction

  task automatic flag_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", field, got, want, $realtime);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    c8ic_pkg::out_t want;
    if (!rst_ni) begin
      foreach (mem_q[i]) mem_q[i] = '0;
      foreach (vreg_q[i]) vreg_q[i] = '0;
      foreach (stack_q[i]) stack_q[i] = '0;
      foreach (screen_q[i]) screen_q[i] = '0;
      depth_q = 0;
      pc_q = c8ic_pkg::PC_START;
      index_q = '0;
      results_q.delete();
      fail_count_o = 0;
    end else begin
      // result side first: an item taken this edge cannot leave this edge
      if (out_valid_i && !out_stall_i) begin
        if (results_q.size() == 0) begin
          $display("unexpected result transaction at %0t", $realtime);
          fail_count_o++;
        end else begin
          want = results_q.pop_front();
          if (out_data_i.pc_after != want.pc_after)
            flag_mismatch("pc_after", out_data_i.pc_after, want.pc_after);
          if (out_data_i.opcode_done != want.opcode_done)
            flag_mismatch("opcode_done", out_data_i.opcode_done, want.opcode_done);
          if (out_data_i.status != want.status)
            flag_mismatch("status", out_data_i.status, want.status);
          if (out_data_i.collision != want.collision)
            flag_mismatch("collision", out_data_i.collision, want.collision);
          if (out_data_i.draw_done != want.draw_done)
            flag_mismatch("draw_done", out_data_i.draw_done, want.draw_done);
          if (out_data_i.display_row != want.display_row)
            flag_mismatch("display_row", out_data_i.display_row, want.display_row);
        end
      end
      if (in_valid_i && !in_stall_i) results_q.push_back(step_core(in_data_i));
    end
  end
endmodule

// ===== tb/sv/tb.sv =====
// testbench top for the chip8 instruction core: clock, reset, stimulus,
// random idling on both channels and the verdict; depends on c8ic_pkg,
// chip8_instruction_core and c8ic_checker
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT = 1_000_000;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_stall;
  c8ic_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  c8ic_pkg::out_t out_data;
  int             fail_count;
  int             pending;
  logic [11:0]    model_pc;

  // idling knobs: idle_on shared by the sender and the receiver, hold_* for the receiver
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int cycles = 0;

  always #1 clk_i = ~clk_i;

  chip8_instruction_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  c8ic_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .pc_o         (model_pc)
  );

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: random stall, plus one long hold-off counted here so the
  // core backs up and stalls its input while the sender keeps offering
  always @(posedge clk_i) begin
    if (hold_req && hold_left == 0) begin
      hold_left <= 300;
      hold_req  <= 1'b0;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idle_on && ($urandom_range(99) < 37);
    end
  end

  // one input transaction; valid stays high when no gap follows
  task automatic send(c8ic_pkg::in_t t);
    in_valid <= 1'b1;
    in_data  <= t;
    // stall is settled by mid-cycle, so the transaction lands on the next edge
    do @(negedge clk_i); while (in_stall);
    @(posedge clk_i);
    if (idle_on && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic send_mode(c8ic_pkg::mode_e m, logic [11:0] adr, logic [7:0] dat);
    c8ic_pkg::in_t t;
    t.mode        = m;
    t.address     = adr;
    t.data_byte   = dat;
    t.random_byte = 8'($urandom);
    t.row_select  = 5'($urandom);
    send(t);
  endtask

  task automatic read_row(logic [4:0] row);
    c8ic_pkg::in_t t;
    t = c8ic_pkg::in_t'(35'({$urandom, $urandom}));
    t.mode       = c8ic_pkg::MODE_READ;
    t.row_select = row;
    send(t);
  endtask

  // stop offering and wait until every result has left
  task automatic drain;
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  // place one instruction word at the current pc and execute it
  task automatic run_instr(logic [15:0] word);
    logic [11:0] at;
    drain();
    at = model_pc;
    send_mode(c8ic_pkg::MODE_WRITE, at, word[15:8]);
    send_mode(c8ic_pkg::MODE_WRITE, at + 12'd1, word[7:0]);
    send_mode(c8ic_pkg::MODE_EXEC, 12'($urandom), 8'($urandom));
  endtask

  function automatic logic [15:0] pick_instr();
    logic [15:0] w;
    w = 16'($urandom);
    case (w[15:12])
      4'h0: case ($urandom_range(2))
        0: w[7:0] = 8'hE0;
        1: w[7:0] = 8'hEE;
        default: ;
      endcase
      4'h1, 4'hB: if ($urandom_range(1)) w[11:8] = 4'hF;
      4'hD: if ($urandom_range(3) == 0) w[3:0] = 4'hF;
      4'hE, 4'hF: if ($urandom_range(2) != 0) w[15:12] = 4'h8;
      default: ;
    endcase
    return w;
  endfunction

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, group 0 cases, underflow, alu flags, draws, wraps
    read_row(5'd0);
    send_mode(c8ic_pkg::MODE_NONE, 12'hFFF, 8'hFF);
    send_mode(c8ic_pkg::MODE_WRITE, 12'hFFF, 8'hFF);
    run_instr(16'h00EE);
    run_instr(16'h6AFF);
    run_instr(16'h7A01);
    run_instr(16'h6BFF);
    run_instr(16'h8AB4);
    run_instr(16'h8AB5);
    run_instr(16'h8FB7);
    run_instr(16'h8BAE);
    run_instr(16'h8B06);
    run_instr(16'h8AB8);
    run_instr(16'hA000);
    run_instr(16'hD01F);
    run_instr(16'hD010);
    run_instr(16'hDAB2);
    read_row(5'd31);
    run_instr(16'h00E0);
    run_instr(16'hE09E);
    run_instr(16'hF00A);
    run_instr(16'hBFFF);
    run_instr(16'h1FFF);
    run_instr(16'hC0FF);
    // fill the return stack past its depth
    for (int k = 0; k <= c8ic_pkg::STACK_DEPTH; k++) run_instr(16'h2800 | 16'(k * 16));
    for (int k = 0; k <= c8ic_pkg::STACK_DEPTH; k++) run_instr(16'h00EE);

    // random: mostly write-and-run instruction sequences with random content
    for (int it = 0; it < 100; it++) begin
      idle_on = !(it >= 30 && it < 55);
      if (it == 70) begin
        // long receiver hold-off while items keep coming
        hold_req = 1'b1;
        for (int k = 0; k < 24; k++) begin
          if (k % 3 == 0) read_row(5'($urandom));
          else send_mode(c8ic_pkg::MODE_WRITE, 12'($urandom), 8'($urandom));
        end
      end
      case ($urandom_range(19))
        0, 1, 2:  send_mode(c8ic_pkg::MODE_WRITE, 12'($urandom), 8'($urandom));
        3, 4:     read_row(5'($urandom));
        5:        send_mode(c8ic_pkg::MODE_NONE, 12'($urandom), 8'($urandom));
        6:        send_mode(c8ic_pkg::MODE_EXEC, 12'($urandom), 8'($urandom));
        default:  run_instr(pick_instr());
      endcase
    end
    idle_on = 1'b1;

    in_valid <= 1'b0;
    drain();
    repeat (60) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
